// ===== hw/rtl/gbn_pkg.sv =====
// shared types and constants of the go-back-n window sender
package gbn_pkg;

  typedef enum logic [1:0] {
    MODE_SEND    = 2'd0,
    MODE_PACKET  = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_RX_TOUT = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_SEGMENT  = 3'd1,
    KIND_COMPLETE = 3'd2,
    KIND_GAVE_UP  = 3'd3,
    KIND_CLOSED   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    RUN_ACTIVE   = 2'd0,
    RUN_COMPLETE = 2'd1,
    RUN_GAVE_UP  = 2'd2,
    RUN_CLOSED   = 2'd3
  } run_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    REG_TRANSFER_LENGTH = 2'd0,
    REG_WINDOW_BYTES    = 2'd1,
    REG_TIMEOUT_TICKS   = 2'd2,
    REG_MAX_TIMEOUTS    = 2'd3
  } reg_e;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  typedef struct packed {
    mode_e        mode;
    logic [31:0]  ack_number;
    logic         is_ack;
    logic         is_fin;
  } in_item_t;

  typedef struct packed {
    kind_e        kind;
    logic [31:0]  seg_start;
    logic [10:0]  seg_len;
    logic [31:0]  seg_seq;
    logic         seg_eof;
  } out_item_t;

  typedef struct packed {
    logic [31:0]  transfer_length;
    logic [15:0]  window_bytes;
    logic [31:0]  timeout_ticks;
    logic [15:0]  max_timeouts;
  } cfg_t;

  typedef struct packed {
    logic [31:0]  seq;
    logic [31:0]  sent_time;
  } slot_t;

endpackage

// ===== hw/rtl/gbn_slot_mem.sv =====
// slot memory: end sequence and send time of each outstanding segment
module gbn_slot_mem import gbn_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr_i,
  input  slot_t                        wr_data_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr_i,
  output slot_t                        rd_data_o
);

  slot_t mem_q [NUM_SLOTS];
  slot_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/gbn_cfg_regs.sv =====
// apb configuration registers
module gbn_cfg_regs import gbn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr_en;

  assign idx   = reg_e'(paddr[AddrWidth-1:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_TRANSFER_LENGTH: cfg_d.transfer_length = pwdata;
        REG_WINDOW_BYTES:    cfg_d.window_bytes    = pwdata[15:0];
        REG_TIMEOUT_TICKS:   cfg_d.timeout_ticks   = pwdata;
        REG_MAX_TIMEOUTS:    cfg_d.max_timeouts    = pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TRANSFER_LENGTH: prdata = cfg_q.transfer_length;
      REG_WINDOW_BYTES:    prdata = {16'd0, cfg_q.window_bytes};
      REG_TIMEOUT_TICKS:   prdata = cfg_q.timeout_ticks;
      REG_MAX_TIMEOUTS:    prdata = {16'd0, cfg_q.max_timeouts};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.transfer_length <= 32'd0;
      cfg_q.window_bytes    <= 16'd4096;
      cfg_q.timeout_ticks   <= 32'd1000;
      cfg_q.max_timeouts    <= 16'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/go_back_n_window_sender_unit.sv =====
// go-back-n window sender: event sequencer around the slot memory
//
// usage: one event per input transfer on in_item_i (send request, arriving
// packet, time tick or receive timeout); each event gives exactly one result
// transfer on out_item_o (kind none, segment, complete, gave up, closed).
// configuration goes through the apb port; the user must only use it while
// the block is idle, which the block does not enforce. send requests, fin
// packets, dropped acks and receive timeouts go from input transfer straight
// to the result step; while running, a valid ack and a time tick first scan
// every slot through the registered memory read port. one event is handled
// at a time: a new one is taken only once the last has left its result step.
// the result sits in an output register, so the next event is taken while a
// result still waits; if the receiver stalls and the register is still full
// when the next event finishes, that event holds in its last step.
// reset: counters cleared, all slots free, configuration back to defaults;
// the slot memory needs no clearing since only data of occupied slots is used.
module go_back_n_window_sender_unit import gbn_pkg::*; #(
  parameter int unsigned NUM_SLOTS     = 8,
  parameter int unsigned PAYLOAD_BYTES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // event input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  localparam int unsigned IdxW = $clog2(NUM_SLOTS);

  cfg_t cfg;

  gbn_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // control state
  state_e               state_q, state_d;
  run_e                 run_q, run_d;
  logic [31:0]          acked_q, acked_d;
  logic [31:0]          unacked_q, unacked_d;
  logic [NUM_SLOTS-1:0] free_q, free_d;
  logic [IdxW-1:0]      ptr_q, ptr_d;
  logic [15:0]          tout_cnt_q, tout_cnt_d;
  logic [31:0]          now_q, now_d;
  // scan sequencer
  logic [IdxW:0]        iss_q, iss_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]      rd_idx_q, rd_idx_d;
  logic                 expired_q, expired_d;
  // result register and latched event
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q, out_item_d;
  in_item_t             item_q;

  logic      accept;
  logic      load;
  logic      scan_done;
  logic      mem_rd_en;
  logic      mem_wr_en;
  slot_t     mem_wr_data;
  slot_t     mem_rd_data;

  gbn_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (ptr_q),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (iss_q[IdxW-1:0]),
    .rd_data_o (mem_rd_data)
  );

  // shared arithmetic on current state
  logic [32:0] sent;
  logic [31:0] left;
  logic [31:0] seg_len;
  logic [32:0] seg_end;
  logic [31:0] now_inc;
  logic        running;
  logic        done_now;
  logic        can_send;
  logic        ack_ok_in;
  logic        ack_ok_item;
  logic [15:0] tout_inc;

  assign sent     = {1'b0, acked_q} + {1'b0, unacked_q};
  assign left     = cfg.transfer_length - sent[31:0];
  assign seg_len  = (left < 32'(PAYLOAD_BYTES)) ? left : 32'(PAYLOAD_BYTES);
  assign seg_end  = sent + {1'b0, seg_len};
  assign now_inc  = now_q + 32'd1;
  assign running  = (run_q == RUN_ACTIVE);
  assign done_now = (cfg.transfer_length != 32'd0) && (acked_q >= cfg.transfer_length);
  assign can_send = (sent < {1'b0, cfg.transfer_length})
                  && (unacked_q < {16'd0, cfg.window_bytes}) && free_q[ptr_q];
  assign ack_ok_in   = in_item_i.is_ack && ({1'b0, in_item_i.ack_number} <= sent)
                     && (in_item_i.ack_number >= acked_q);
  assign ack_ok_item = item_q.is_ack && ({1'b0, item_q.ack_number} <= sent)
                     && (item_q.ack_number >= acked_q);
  assign tout_inc    = tout_cnt_q + 16'd1;

  assign accept    = in_valid_i && in_ready_o;
  assign load      = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign scan_done = rd_vld_q && (rd_idx_q == IdxW'(NUM_SLOTS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // while running, ticks and valid non-fin acks walk the slots, the rest finish directly
          if (running && ((in_item_i.mode == MODE_TICK) ||
              ((in_item_i.mode == MODE_PACKET) && !in_item_i.is_fin && ack_ok_in))) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    mem_rd_en  = (state_q == ST_SCAN) && (iss_q < (IdxW+1)'(NUM_SLOTS));
    mem_wr_en  = load && running && (item_q.mode == MODE_SEND) && !done_now && can_send;
  end

  assign mem_wr_data.seq       = seg_end[31:0];
  assign mem_wr_data.sent_time = now_q;

  // datapath: scan compare and event commit
  always_comb begin
    run_d       = run_q;
    acked_d     = acked_q;
    unacked_d   = unacked_q;
    free_d      = free_q;
    ptr_d       = ptr_q;
    tout_cnt_d  = tout_cnt_q;
    now_d       = now_q;
    iss_d       = iss_q;
    rd_vld_d    = mem_rd_en;
    rd_idx_d    = iss_q[IdxW-1:0];
    expired_d   = expired_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (accept) begin
      iss_d     = '0;
      expired_d = 1'b0;
    end
    if (mem_rd_en) begin
      iss_d = iss_q + (IdxW+1)'(1);
    end

    // one slot per cycle, data arrives the cycle after the read
    if ((state_q == ST_SCAN) && rd_vld_q && !free_q[rd_idx_q]) begin
      if (item_q.mode == MODE_PACKET) begin
        if (mem_rd_data.seq <= item_q.ack_number) begin
          free_d[rd_idx_q] = 1'b1;
        end
      end else if ((now_inc - mem_rd_data.sent_time) > cfg.timeout_ticks) begin
        expired_d = 1'b1;
      end
    end

    if (load) begin
      out_valid_d = 1'b1;
      out_item_d  = '0;
      out_item_d.kind = KIND_NONE;
      if (running) begin
        unique case (item_q.mode)
          MODE_SEND: begin
            if (done_now) begin
              run_d           = RUN_COMPLETE;
              out_item_d.kind = KIND_COMPLETE;
            end else if (can_send) begin
              unacked_d            = unacked_q + seg_len;
              free_d[ptr_q]        = 1'b0;
              ptr_d                = (ptr_q == IdxW'(NUM_SLOTS - 1)) ? '0
                                   : ptr_q + IdxW'(1);
              out_item_d.kind      = KIND_SEGMENT;
              out_item_d.seg_start = sent[31:0];
              out_item_d.seg_len   = seg_len[10:0];
              out_item_d.seg_seq   = seg_end[31:0];
              out_item_d.seg_eof   = (seg_end >= {1'b0, cfg.transfer_length});
            end
          end
          MODE_PACKET: begin
            if (item_q.is_fin) begin
              run_d           = RUN_CLOSED;
              out_item_d.kind = KIND_CLOSED;
            end else if (ack_ok_item) begin
              // slots were freed during the scan
              unacked_d  = unacked_q - (item_q.ack_number - acked_q);
              acked_d    = item_q.ack_number;
              tout_cnt_d = 16'd0;
              if ((cfg.transfer_length != 32'd0) &&
                  (item_q.ack_number >= cfg.transfer_length)) begin
                run_d           = RUN_COMPLETE;
                out_item_d.kind = KIND_COMPLETE;
              end
            end
          end
          MODE_TICK: begin
            now_d = now_inc;
            // go back: everything unacked is resent from the acked count
            if (expired_q) begin
              unacked_d = 32'd0;
              free_d    = '1;
            end
          end
          MODE_RX_TOUT: begin
            if (tout_cnt_q != 16'hFFFF) begin
              tout_cnt_d = tout_inc;
            end
            if (tout_cnt_d >= cfg.max_timeouts) begin
              run_d           = RUN_GAVE_UP;
              out_item_d.kind = KIND_GAVE_UP;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= RUN_ACTIVE;
      acked_q     <= 32'd0;
      unacked_q   <= 32'd0;
      free_q      <= '1;
      ptr_q       <= '0;
      tout_cnt_q  <= 16'd0;
      now_q       <= 32'd0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      expired_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      acked_q     <= acked_d;
      unacked_q   <= unacked_d;
      free_q      <= free_d;
      ptr_q       <= ptr_d;
      tout_cnt_q  <= tout_cnt_d;
      now_q       <= now_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      expired_q   <= expired_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
